// ===== hdl/pixel_to_glyph_downscaler_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pixel to glyph downscaler
// Concurrent checks that are clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_GLYPH_DOWNSCALER_UNIT_MACROS_SVH
`define PIXEL_TO_GLYPH_DOWNSCALER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGD_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PGD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/pgd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel to glyph downscaler package
// Shared constants, register indexes, structures and small arithmetic helpers.
// ----------------------------------------------------------------------------
package pgd_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int MAX_LEVELS    = 64;

    localparam logic [2:0] REG_SOURCE_WIDTH    = 3'd0;
    localparam logic [2:0] REG_SOURCE_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_SCALED_WIDTH    = 3'd2;
    localparam logic [2:0] REG_SCALED_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_INVERT_MODE     = 3'd4;
    localparam logic [2:0] REG_NORMAL_LEVELS   = 3'd5;
    localparam logic [2:0] REG_INVERTED_LEVELS = 3'd6;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [12:0] scaled_width;
        logic [12:0] scaled_height;
        logic [6:0]  levels;
    } cfg_t;

    typedef struct packed {
        logic [1:0] count;
        logic [5:0] level;
        logic       line_end0;
        logic       frame_end0;
        logic       run_last0;
        logic       line_end1;
        logic       frame_end1;
    } glyph_pair_t;

    // Exact floor(v / 3) for all 8-bit values through a reciprocal multiply.
    function automatic logic [7:0] div3(input logic [7:0] v);
        logic [16:0] p;
        p = {9'd0, v} * 17'd171;
        return p[16:9];
    endfunction

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input logic [12:0] hi);
        logic [12:0] r;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [6:0] clamp_levels(input logic [6:0] v);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > 7'(MAX_LEVELS)) begin
            r = 7'(MAX_LEVELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hdl/pgd_config.sv =====
// ----------------------------------------------------------------------------
// Pixel to glyph downscaler configuration registers
// Holds the register file, clamps the dimensions and selects the level count.
// ----------------------------------------------------------------------------
module pgd_config
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [12:0]        cfg_data,
    output pgd_pkg::cfg_t      cfg,
    output logic               restart
);

    logic [12:0] source_width_reg;
    logic [12:0] source_height_reg;
    logic [12:0] scaled_width_reg;
    logic [12:0] scaled_height_reg;
    logic        invert_mode_reg;
    logic [6:0]  normal_levels_reg;
    logic [6:0]  inverted_levels_reg;
    logic        write_en;
    logic        index_hit;
    logic [12:0] width_clamped;
    logic [12:0] height_clamped;

    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid && cfg_ready;

    always_comb
    begin
        case (cfg_index)
            pgd_pkg::REG_SOURCE_WIDTH,
            pgd_pkg::REG_SOURCE_HEIGHT,
            pgd_pkg::REG_SCALED_WIDTH,
            pgd_pkg::REG_SCALED_HEIGHT,
            pgd_pkg::REG_INVERT_MODE,
            pgd_pkg::REG_NORMAL_LEVELS,
            pgd_pkg::REG_INVERTED_LEVELS: index_hit = 1'b1;
            default:                      index_hit = 1'b0;
        endcase
    end

    assign restart = write_en && index_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg    <= 13'd1;
            source_height_reg   <= 13'd1;
            scaled_width_reg    <= 13'd1;
            scaled_height_reg   <= 13'd1;
            invert_mode_reg     <= 1'b0;
            normal_levels_reg   <= 7'd1;
            inverted_levels_reg <= 7'd1;
        end
        else if (write_en)
        begin
            case (cfg_index)
                pgd_pkg::REG_SOURCE_WIDTH:    source_width_reg    <= cfg_data;
                pgd_pkg::REG_SOURCE_HEIGHT:   source_height_reg   <= cfg_data;
                pgd_pkg::REG_SCALED_WIDTH:    scaled_width_reg    <= cfg_data;
                pgd_pkg::REG_SCALED_HEIGHT:   scaled_height_reg   <= cfg_data;
                pgd_pkg::REG_INVERT_MODE:     invert_mode_reg     <= cfg_data[0];
                pgd_pkg::REG_NORMAL_LEVELS:   normal_levels_reg   <= cfg_data[6:0];
                pgd_pkg::REG_INVERTED_LEVELS: inverted_levels_reg <= cfg_data[6:0];
                default:                      ;
            endcase
        end
    end

    assign width_clamped  = pgd_pkg::clamp_dim(source_width_reg, 13'(pgd_pkg::MAX_DIMENSION));
    assign height_clamped = pgd_pkg::clamp_dim(source_height_reg, 13'(pgd_pkg::MAX_DIMENSION));

    always_comb
    begin
        cfg.width         = width_clamped;
        cfg.height        = height_clamped;
        cfg.scaled_width  = pgd_pkg::clamp_dim(scaled_width_reg, width_clamped);
        cfg.scaled_height = pgd_pkg::clamp_dim(scaled_height_reg, height_clamped);
        cfg.levels        = pgd_pkg::clamp_levels(invert_mode_reg ? inverted_levels_reg
                                                                  : normal_levels_reg);
    end

endmodule

// ===== hdl/pgd_sampler.sv =====
// ----------------------------------------------------------------------------
// Pixel to glyph downscaler sampler
// Keeps the raster position and step accumulators and decides, for each
// pixel, which glyphs it yields and their level and boundary flags.
// ----------------------------------------------------------------------------
module pgd_sampler
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pgd_pkg::cfg_t         cfg,
    input  logic                  restart,
    input  logic                  step,
    input  logic [7:0]            gray,
    output pgd_pkg::glyph_pair_t  pair
);

    logic [11:0] src_column_reg;
    logic [11:0] src_row_reg;
    logic [13:0] glyph_column_reg;
    logic [12:0] glyph_row_reg;
    logic [14:0] column_acc_reg;
    logic [13:0] row_acc_reg;

    logic [13:0] glyphs;
    logic [14:0] glyphs_wide;
    logic [14:0] width_wide;
    logic        row_hit;
    logic        emit0;
    logic        emit1;
    logic [13:0] glyph_column_1;
    logic [13:0] glyph_column_next;
    logic [14:0] column_acc_1;
    logic [14:0] column_acc_2;
    logic [14:0] column_acc_next;
    logic [14:0] level_product;
    logic        last_row;
    logic        line_end0;
    logic        line_end1;
    logic [12:0] src_column_inc;
    logic [12:0] src_row_inc;
    logic        row_done;
    logic        frame_done;
    logic [13:0] row_acc_add;
    logic [13:0] row_acc_next;

    always_comb
    begin
        glyphs      = {cfg.scaled_width, 1'b0};
        glyphs_wide = {1'b0, glyphs};
        width_wide  = {2'b00, cfg.width};

        row_hit = (glyph_row_reg < cfg.scaled_height)
                  && (row_acc_reg < {1'b0, cfg.scaled_height});

        emit0          = row_hit && (glyph_column_reg < glyphs) && (column_acc_reg < glyphs_wide);
        glyph_column_1 = glyph_column_reg + 14'd1;
        column_acc_1   = emit0 ? column_acc_reg + width_wide : column_acc_reg;
        emit1          = emit0 && (glyph_column_1 < glyphs) && (column_acc_1 < glyphs_wide);
        column_acc_2   = emit1 ? column_acc_1 + width_wide : column_acc_1;

        glyph_column_next = glyph_column_reg + {13'd0, emit0} + {13'd0, emit1};
        if (!row_hit)
        begin
            column_acc_next = column_acc_reg;
        end
        else if (column_acc_2 >= glyphs_wide)
        begin
            column_acc_next = column_acc_2 - glyphs_wide;
        end
        else
        begin
            column_acc_next = 15'd0;
        end

        level_product = {7'd0, gray} * {8'd0, cfg.levels};

        last_row  = glyph_row_reg == cfg.scaled_height - 13'd1;
        line_end0 = glyph_column_reg == glyphs - 14'd1;
        line_end1 = glyph_column_1 == glyphs - 14'd1;

        pair.count      = emit1 ? 2'd2 : (emit0 ? 2'd1 : 2'd0);
        pair.level      = level_product[13:8];
        pair.line_end0  = line_end0;
        pair.frame_end0 = line_end0 && last_row;
        pair.run_last0  = !emit1;
        pair.line_end1  = line_end1;
        pair.frame_end1 = line_end1 && last_row;

        src_column_inc = {1'b0, src_column_reg} + 13'd1;
        src_row_inc    = {1'b0, src_row_reg} + 13'd1;
        row_done       = src_column_inc >= cfg.width;
        frame_done     = row_done && (src_row_inc >= cfg.height);

        row_acc_add = row_hit ? row_acc_reg + {1'b0, cfg.height} : row_acc_reg;
        if (row_acc_add >= {1'b0, cfg.scaled_height})
        begin
            row_acc_next = row_acc_add - {1'b0, cfg.scaled_height};
        end
        else
        begin
            row_acc_next = 14'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_column_reg   <= 12'd0;
            src_row_reg      <= 12'd0;
            glyph_column_reg <= 14'd0;
            glyph_row_reg    <= 13'd0;
            column_acc_reg   <= 15'd0;
            row_acc_reg      <= 14'd0;
        end
        else if (restart || (step && frame_done))
        begin
            src_column_reg   <= 12'd0;
            src_row_reg      <= 12'd0;
            glyph_column_reg <= 14'd0;
            glyph_row_reg    <= 13'd0;
            column_acc_reg   <= 15'd0;
            row_acc_reg      <= 14'd0;
        end
        else if (step && row_done)
        begin
            src_column_reg   <= 12'd0;
            glyph_column_reg <= 14'd0;
            column_acc_reg   <= 15'd0;
            glyph_row_reg    <= glyph_row_reg + {12'd0, row_hit};
            row_acc_reg      <= row_acc_next;
            src_row_reg      <= src_row_inc[11:0];
        end
        else if (step)
        begin
            src_column_reg   <= src_column_inc[11:0];
            glyph_column_reg <= glyph_column_next;
            column_acc_reg   <= column_acc_next;
        end
    end

endmodule

// ===== hdl/pgd_out_buffer.sv =====
// ----------------------------------------------------------------------------
// Pixel to glyph downscaler result buffer
// Holds the up to two glyphs of one pixel and hands them out one per transfer.
// ----------------------------------------------------------------------------
module pgd_out_buffer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  pgd_pkg::glyph_pair_t  pair,
    input  logic                  stall,
    output logic                  valid,
    output logic [5:0]            level,
    output logic                  run_last,
    output logic                  line_end,
    output logic                  frame_end,
    output logic                  free
);

    logic [1:0] count_reg;
    logic [5:0] level_reg;
    logic       line_end0_reg;
    logic       frame_end0_reg;
    logic       run_last0_reg;
    logic       line_end1_reg;
    logic       frame_end1_reg;
    logic       transfer;

    assign valid    = count_reg != 2'd0;
    assign transfer = valid && !stall;
    assign free     = (count_reg == 2'd0) || ((count_reg == 2'd1) && !stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (load)
        begin
            count_reg <= pair.count;
        end
        else if (transfer)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            level_reg      <= pair.level;
            line_end0_reg  <= pair.line_end0;
            frame_end0_reg <= pair.frame_end0;
            run_last0_reg  <= pair.run_last0;
            line_end1_reg  <= pair.line_end1;
            frame_end1_reg <= pair.frame_end1;
        end
        else if (transfer && (count_reg == 2'd2))
        begin
            line_end0_reg  <= line_end1_reg;
            frame_end0_reg <= frame_end1_reg;
            run_last0_reg  <= 1'b1;
        end
    end

    assign level     = level_reg;
    assign run_last  = run_last0_reg;
    assign line_end  = line_end0_reg;
    assign frame_end = frame_end0_reg;

endmodule

// ===== hdl/pixel_to_glyph_downscaler_unit.sv =====
// ----------------------------------------------------------------------------
// Pixel to glyph downscaler
// Nearest-neighbor downscaling of a raster RGB stream to gray glyph levels.
// ----------------------------------------------------------------------------
// A pixel transfer is taken into an input register together with its gray
// value; once the result buffer is free, the sampler decides the pixel's zero,
// one or two glyphs and loads them into the result buffer. The result channel
// moves one glyph per cycle while glyph_stall is low, and the buffer takes the
// next pixel as the last glyph of the one before leaves. Configuration writes
// are always ready, take effect at once and restart the frame; they belong to
// idle periods.
module pixel_to_glyph_downscaler_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        glyph_valid,
    input  logic        glyph_stall,
    output logic [5:0]  glyph_level,
    output logic        run_last,
    output logic        line_end,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

`include "pixel_to_glyph_downscaler_unit_macros.svh"

    pgd_pkg::cfg_t        cfg;
    pgd_pkg::glyph_pair_t pair;
    logic                 restart;
    logic                 pix_valid_reg;
    logic                 pix_valid_next;
    logic [7:0]           pix_gray_reg;
    logic [7:0]           pix_gray_next;
    logic                 buf_free;
    logic                 move;
    logic                 in_transfer;

    pgd_config u_config
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .restart   (restart)
    );

    assign move        = pix_valid_reg && buf_free;
    assign pixel_stall = pix_valid_reg && !buf_free;
    assign in_transfer = pixel_valid && !pixel_stall;

    always_comb
    begin
        pix_gray_next = pgd_pkg::div3(red) + pgd_pkg::div3(green) + pgd_pkg::div3(blue);
        if (in_transfer)
        begin
            pix_valid_next = 1'b1;
        end
        else if (move)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            pix_gray_reg <= pix_gray_next;
        end
    end

    pgd_sampler u_sampler
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .restart (restart),
        .step    (move),
        .gray    (pix_gray_reg),
        .pair    (pair)
    );

    pgd_out_buffer u_out_buffer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .pair      (pair),
        .stall     (glyph_stall),
        .valid     (glyph_valid),
        .level     (glyph_level),
        .run_last  (run_last),
        .line_end  (line_end),
        .frame_end (frame_end),
        .free      (buf_free)
    );

    `PGD_ASSERT_IMPLY(a_frame_end_is_line_end, glyph_valid && frame_end, line_end)
    `PGD_ASSERT_IMPLY(a_empty_buffer_takes_pixel, pix_valid_reg && !glyph_valid, !pixel_stall)
    `PGD_ASSERT_NEXT(a_second_glyph_follows, glyph_valid && !glyph_stall && !run_last, glyph_valid)
    `PGD_ASSERT_IMPLY(a_stall_needs_held_pixel, pixel_stall, pix_valid_reg && glyph_valid)

endmodule
